@@ hw/rtl/pta_pkg.sv @@
// Shared types and constants for the periodic timeslot arbiter.
package pta_pkg;

   // Width of the configuration registers and of the length and time fields.
   localparam int CFG_W = 24;
   localparam int LEN_W = 24;

   // Default timer width.
   localparam int TIMER_BITS_DEFAULT = 24;

   // Register reset values, in microseconds.
   localparam logic [CFG_W-1:0] CYCLE_LENGTH_RESET = 24'd250000;
   localparam logic [CFG_W-1:0] SLOT_START_RESET   = 24'd10000;
   localparam logic [CFG_W-1:0] MARGIN_RESET       = 24'd150;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_START   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN       = 2'd2;

   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_ENTER_CONT = 3'd1,
      CMD_EXIT_CONT  = 3'd2,
      CMD_ENTER_CRIT = 3'd3,
      CMD_EXIT_CRIT  = 3'd4,
      CMD_REQUEST    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_OPEN  = 2'd1,
      EV_CLOSE = 2'd2
   } event_type;

   typedef struct packed {
      cmd_type          command;
      logic [LEN_W-1:0] request_length_us;
   } req_word_type;

   typedef struct packed {
      logic             slot_granted;
      logic             slot_started_pulse;
      logic             slot_ended_pulse;
      logic             request_accepted;
      logic [LEN_W-1:0] time_left_us;
   } rsp_word_type;

   // Arbiter flags carried between the state registers and the step logic.
   typedef struct packed {
      logic      mode_requested;
      logic      granted_flag;
      logic      in_critical;
      event_type deferred_event;
   } flags_type;

endpackage

@@ hw/rtl/periodic_timeslot_arbiter_core.sv @@
// Top level of the periodic timeslot arbiter: registers, handshakes and configuration.
//
//   Channel   Direction   Handshake          Word
//   req_      in          valid / stall      command, request_length_us
//   rsp_      out         valid / stall      grant, pulses, acceptance, time left
//   csr_      in          valid / ready      register index, write data
//
// Each accepted word is registered in the input register, processed by the step
// logic and registered in the result register, so its result word is offered after
// both registers; one word is taken every cycle while the result side does not stall.
// The step logic is one increment, one add for the request end, a few compares
// against the slot limits and one subtract for the remaining time.
// Reset is synchronous and active high; it clears the timer, the flags, both
// valid bits and loads the configuration registers with their default values.
// A stall on the result side holds the result register; the input register then
// holds too, and req_stall rises only while the input register is full and blocked.
// Configuration writes are taken whenever the input register is empty.
module periodic_timeslot_arbiter_core #(
   parameter int TIMER_BITS = pta_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pta_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pta_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pta_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pta_pkg::CFG_W-1:0]            csr_data
);

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   pta_pkg::req_word_type in_word_ff, in_word_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   pta_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Arbiter state.
   logic [TIMER_BITS-1:0] counter_ff, counter_in;
   pta_pkg::flags_type    flags_ff, flags_in;

   // Configuration registers. The slot end is kept precomputed so the step
   // logic need not compute it from the cycle length and margin.
   logic [pta_pkg::CFG_W-1:0] cycle_length_ff, cycle_length_in;
   logic [pta_pkg::CFG_W-1:0] slot_start_ff, slot_start_in;
   logic [pta_pkg::CFG_W-1:0] margin_ff, margin_in;
   logic [TIMER_BITS-1:0]     slot_end_ff, slot_end_in;

   logic                  advance;
   logic                  req_take;
   logic                  csr_write;
   logic [TIMER_BITS-1:0] step_counter;
   pta_pkg::flags_type    step_flags;
   pta_pkg::rsp_word_type step_result;

   // The word in the input register moves on when the result register is
   // empty or its word is being taken this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign csr_ready = !in_valid_ff;
   assign csr_write = csr_valid && csr_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   pta_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .word         (in_word_ff),
      .counter      (counter_ff),
      .flags        (flags_ff),
      .cycle_len    (TIMER_BITS'(cycle_length_ff)),
      .slot_start   (TIMER_BITS'(slot_start_ff)),
      .slot_end     (slot_end_ff),
      .counter_next (step_counter),
      .flags_next   (step_flags),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      counter_in   = counter_ff;
      flags_in     = flags_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = step_result;
         counter_in   = step_counter;
         flags_in     = step_flags;
      end
   end

   // Register writes; the slot end follows the cycle length and margin, both
   // taken modulo the timer width.
   always_comb begin
      cycle_length_in = cycle_length_ff;
      slot_start_in   = slot_start_ff;
      margin_in       = margin_ff;
      slot_end_in     = slot_end_ff;
      if (csr_write) begin
         unique case (csr_index)
            pta_pkg::CSR_CYCLE_LENGTH: begin
               cycle_length_in = csr_data;
               slot_end_in     = TIMER_BITS'(csr_data) - TIMER_BITS'(margin_ff);
            end
            pta_pkg::CSR_SLOT_START: begin
               slot_start_in = csr_data;
            end
            pta_pkg::CSR_MARGIN: begin
               margin_in   = csr_data;
               slot_end_in = TIMER_BITS'(cycle_length_ff) - TIMER_BITS'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         counter_ff      <= '0;
         flags_ff        <= '{mode_requested: 1'b0, granted_flag: 1'b0,
                              in_critical: 1'b0, deferred_event: pta_pkg::EV_NONE};
         cycle_length_ff <= pta_pkg::CYCLE_LENGTH_RESET;
         slot_start_ff   <= pta_pkg::SLOT_START_RESET;
         margin_ff       <= pta_pkg::MARGIN_RESET;
         slot_end_ff     <= TIMER_BITS'(pta_pkg::CYCLE_LENGTH_RESET) -
                            TIMER_BITS'(pta_pkg::MARGIN_RESET);
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         counter_ff      <= counter_in;
         flags_ff        <= flags_in;
         cycle_length_ff <= cycle_length_in;
         slot_start_ff   <= slot_start_in;
         margin_ff       <= margin_in;
         slot_end_ff     <= slot_end_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

@@ hw/rtl/pta_step.sv @@
// Combinational update of the arbiter state and result word for one input word.
module pta_step #(
   parameter int TIMER_BITS = pta_pkg::TIMER_BITS_DEFAULT
) (
   input  pta_pkg::req_word_type  word,
   input  logic [TIMER_BITS-1:0]  counter,
   input  pta_pkg::flags_type     flags,
   input  logic [TIMER_BITS-1:0]  cycle_len,
   input  logic [TIMER_BITS-1:0]  slot_start,
   input  logic [TIMER_BITS-1:0]  slot_end,
   output logic [TIMER_BITS-1:0]  counter_next,
   output pta_pkg::flags_type     flags_next,
   output pta_pkg::rsp_word_type  result
);

   localparam int SumW = ((TIMER_BITS > pta_pkg::LEN_W) ? TIMER_BITS : pta_pkg::LEN_W) + 1;
   localparam logic [TIMER_BITS-1:0] LeftMax = TIMER_BITS'({pta_pkg::LEN_W{1'b1}});

   logic [TIMER_BITS-1:0] count_inc;
   logic [TIMER_BITS-1:0] left_full;
   logic [SumW-1:0]       req_sum;
   logic                  started;
   logic                  ended;
   logic                  accepted;
   logic                  in_window;

   assign count_inc = counter + TIMER_BITS'(1);
   assign req_sum   = SumW'(counter) + SumW'(word.request_length_us);

   always_comb begin
      counter_next = counter;
      flags_next   = flags;
      started      = 1'b0;
      ended        = 1'b0;
      accepted     = 1'b0;
      unique case (word.command)
         pta_pkg::CMD_TICK: begin
            counter_next = count_inc;
            // Open compare first, then close, then the cycle clear.
            if (count_inc == slot_start) begin
               if (flags_next.in_critical) begin
                  flags_next.deferred_event =
                     (flags_next.deferred_event == pta_pkg::EV_CLOSE) ?
                     pta_pkg::EV_NONE : pta_pkg::EV_OPEN;
               end else if (flags_next.mode_requested && !flags_next.granted_flag) begin
                  flags_next.granted_flag = 1'b1;
                  started = 1'b1;
               end
            end
            if (count_inc == slot_end) begin
               if (flags_next.in_critical) begin
                  flags_next.deferred_event =
                     (flags_next.deferred_event == pta_pkg::EV_OPEN) ?
                     pta_pkg::EV_NONE : pta_pkg::EV_CLOSE;
               end else if (flags_next.mode_requested && flags_next.granted_flag) begin
                  flags_next.granted_flag = 1'b0;
                  ended = 1'b1;
               end
            end
            if (count_inc == cycle_len) begin
               counter_next = '0;
            end
         end
         pta_pkg::CMD_ENTER_CONT: begin
            flags_next.mode_requested = 1'b1;
            flags_next.deferred_event = pta_pkg::EV_NONE;
         end
         pta_pkg::CMD_EXIT_CONT: begin
            flags_next.mode_requested = 1'b0;
            flags_next.granted_flag   = 1'b0;
         end
         pta_pkg::CMD_ENTER_CRIT: begin
            flags_next.in_critical = 1'b1;
         end
         pta_pkg::CMD_EXIT_CRIT: begin
            flags_next.in_critical = 1'b0;
            if (flags.deferred_event == pta_pkg::EV_OPEN) begin
               if (flags.mode_requested && !flags.granted_flag) begin
                  flags_next.granted_flag = 1'b1;
                  started = 1'b1;
               end
            end else if (flags.deferred_event == pta_pkg::EV_CLOSE) begin
               if (flags.mode_requested && flags.granted_flag) begin
                  flags_next.granted_flag = 1'b0;
                  ended = 1'b1;
               end
            end
            flags_next.deferred_event = pta_pkg::EV_NONE;
         end
         pta_pkg::CMD_REQUEST: begin
            accepted = flags.granted_flag && (counter >= slot_start) &&
                       (req_sum < SumW'(slot_end));
         end
         default: begin
         end
      endcase
   end

   assign in_window = (counter_next >= slot_start) && (counter_next < slot_end);
   assign left_full = slot_end - counter_next;

   always_comb begin
      result.slot_granted       = flags_next.granted_flag;
      result.slot_started_pulse = started;
      result.slot_ended_pulse   = ended;
      result.request_accepted   = accepted;
      if (!in_window) begin
         result.time_left_us = '0;
      end else if (left_full > LeftMax) begin
         result.time_left_us = {pta_pkg::LEN_W{1'b1}};
      end else begin
         result.time_left_us = pta_pkg::LEN_W'(left_full);
      end
   end

endmodule

@@ hw/rtl/pta_checker.sv @@
// Port-level assertions for the periodic timeslot arbiter and their bind.
module pta_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input pta_pkg::rsp_word_type           rsp_word
);

   // No result word is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // A revoke always leaves the slot released; a lone grant leaves it held.
   a_pulse_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.slot_ended_pulse ||
                    (rsp_word.slot_started_pulse && !rsp_word.slot_granted)) |->
      !rsp_word.slot_granted && rsp_word.slot_ended_pulse)
      else $error("pulse does not match grant state");

   // An accepted slot request needs a held slot.
   a_request_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.request_accepted |-> rsp_word.slot_granted)
      else $error("request accepted without grant");

   // A grant that is still held cannot be granted again by the next word.
   a_no_double_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word.slot_started_pulse &&
       !rsp_word.slot_ended_pulse) ##1 rsp_valid |-> !rsp_word.slot_started_pulse)
      else $error("slot granted twice in a row");

endmodule

bind periodic_timeslot_arbiter_core pta_checker u_pta_checker (.*);
